// File: rtl/fltpw_pkg.sv
// ----------------------------------------------------------------------------
// fltpw_pkg: shared types and constants of the four-level page table walker
// field widths, status and command codes, entry flag bits
// ----------------------------------------------------------------------------
package fltpw_pkg;

	localparam int TABLE_FRAMES_DEF = 64;

	localparam int VA_W     = 48;
	localparam int PA_W     = 52;
	localparam int FLAGS_W  = 12;
	localparam int ENTRY_W  = 52;
	localparam int FRAME_W  = 40;
	localparam int IDX_W    = 9;
	localparam int STATUS_W = 2;

	localparam int S_TDATA_W = 112;
	localparam int M_TDATA_W = 56;

	localparam logic CMD_TRANSLATE = 1'b0;
	localparam logic CMD_MAP       = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_UNMAPPED  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_FRAMES = 2'd2;

	// intermediate links are present and writable
	localparam logic [FLAGS_W-1:0] LINK_FLAGS = 12'h003;

	// result of checking one table entry as a link
	typedef struct packed {
		logic present;
		logic in_store;
	} link_chk_t;

endpackage

// File: rtl/fltpw_table_store.sv
// ----------------------------------------------------------------------------
// fltpw_table_store: table frame memory
// one write and one registered read per cycle, zeroing sweep after reset
// ----------------------------------------------------------------------------
module fltpw_table_store #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [fltpw_pkg::ENTRY_W-1:0] wr_data,
	input  logic [AW-1:0]                 rd_addr,
	output logic [fltpw_pkg::ENTRY_W-1:0] rd_data,
	output logic                          clear_busy
);
	import fltpw_pkg::*;

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [AW-1:0]      clr_addr_q;
	logic               clear_busy_q;

	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic [ENTRY_W-1:0] mem_wdata;

	// sweep owns the write port until done
	assign mem_we    = clear_busy_q | wr_en;
	assign mem_addr  = clear_busy_q ? clr_addr_q : wr_addr;
	assign mem_wdata = clear_busy_q ? '0 : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			clear_busy_q <= 1'b1;
		end else if (clear_busy_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clear_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data    = rd_data_q;
	assign clear_busy = clear_busy_q;

endmodule

// File: rtl/fltpw_link_unit.sv
// ----------------------------------------------------------------------------
// fltpw_link_unit: shared link check and link builder
// maps an entry's frame address to a store frame, forms new link entries
// ----------------------------------------------------------------------------
module fltpw_link_unit #(
	parameter int FW  = 6,
	parameter int NFW = 7
) (
	input  logic [fltpw_pkg::ENTRY_W-1:0] entry,
	input  logic [fltpw_pkg::FRAME_W-1:0] base_frame,
	input  logic [NFW-1:0]                next_free,
	output fltpw_pkg::link_chk_t          chk,
	output logic [FW-1:0]                 frame,
	output logic [fltpw_pkg::ENTRY_W-1:0] new_link
);
	import fltpw_pkg::*;

	logic [FRAME_W-1:0] diff;
	logic [FRAME_W-1:0] free_ext;
	logic [FRAME_W-1:0] fresh_phys;

	assign free_ext = FRAME_W'(next_free);

	// store-relative frame, wraps modulo 2^40
	assign diff = entry[ENTRY_W-1 -: FRAME_W] - base_frame;

	// next_free never exceeds the frame count, so one compare covers both bounds
	assign chk.present  = entry[0];
	assign chk.in_store = (diff < free_ext);
	assign frame        = diff[FW-1:0];

	assign fresh_phys = base_frame + free_ext;
	assign new_link   = {fresh_phys, LINK_FLAGS};

endmodule

// File: rtl/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker: four-level page table walk and map
// translates or maps one virtual address per command over a local table store
// ----------------------------------------------------------------------------
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   tdata: virt_addr, phys_addr, page_flags; tuser: cmd
// m_       out  m_tvalid/m_tready   tdata: result_addr; tuser: status
// cfg_     in   cfg_wr_en           cfg_wr_data: table_base_frame
//
// a command is accepted from idle, then each level takes a store read state and a check state,
//   up to four levels, and a final state hands the result to the output register, waiting there
//   while the output still holds an untaken result; fewer levels are walked when a level misses early
// the single store read port and the shared link unit handle one level at a time
// after reset the store is zeroed one entry a cycle, all TABLE_FRAMES*512 entries,
//   with s_tready low; config writes are taken throughout
// a new command is taken while the previous result still waits on m_tready
//
module four_level_page_table_walker #(
	parameter int TABLE_FRAMES = fltpw_pkg::TABLE_FRAMES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [47:0] virt_addr, [99:48] phys_addr, [111:100] page_flags
	input  logic [fltpw_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] cmd
	input  logic [0:0]                      s_tuser,
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [51:0] result_addr, [55:52] zero
	output logic [fltpw_pkg::M_TDATA_W-1:0] m_tdata,
	// [1:0] status
	output logic [fltpw_pkg::STATUS_W-1:0]  m_tuser,
	// table_base_frame register
	input  logic                            cfg_wr_en,
	input  logic [fltpw_pkg::FRAME_W-1:0]   cfg_wr_data
);
	import fltpw_pkg::*;

	localparam int FW    = $clog2(TABLE_FRAMES);
	localparam int NFW   = $clog2(TABLE_FRAMES + 1);
	localparam int AW    = FW + IDX_W;
	localparam int DEPTH = TABLE_FRAMES * (2 ** IDX_W);

	localparam logic [NFW-1:0] FRAMES_LIM = NFW'(TABLE_FRAMES);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EVAL = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic [1:0] LVL_ROOT = 2'd0;
	localparam logic [1:0] LVL_LEAF = 2'd3;

	// 9-bit table index for a level: bits 47..39, 38..30, 29..21, 20..12
	function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
			input logic [1:0] level);
		logic [IDX_W-1:0] idx;
		unique case (level)
			2'd0: idx = va[47:39];
			2'd1: idx = va[38:30];
			2'd2: idx = va[29:21];
			2'd3: idx = va[20:12];
		endcase
		return idx;
	endfunction

	logic [1:0]           state_q;
	logic [1:0]           level_q;
	logic                 cmd_q;
	logic [VA_W-1:0]      va_q;
	logic [PA_W-13:0]     pa_page_q;
	logic [FLAGS_W-1:0]   flags_q;
	logic [AW-1:0]        addr_q;
	logic [NFW-1:0]       next_free_q;
	logic [FRAME_W-1:0]   base_q;
	logic [PA_W-1:0]      res_addr_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic                 m_tvalid_q;
	logic [PA_W-1:0]      m_addr_q;
	logic [STATUS_W-1:0]  m_status_q;

	logic                 s_xfer;
	logic                 fin_load;
	logic                 last_lvl;
	logic                 frames_left;
	logic                 clear_busy;
	logic [ENTRY_W-1:0]   rd_data;
	logic                 mem_we;
	logic [ENTRY_W-1:0]   mem_wdata;
	link_chk_t            chk;
	logic [FW-1:0]        link_frame;
	logic [ENTRY_W-1:0]   new_link;
	logic [IDX_W-1:0]     next_idx;
	logic [FW-1:0]        fresh_frame;

	// table store and zeroing sweep
	fltpw_table_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (mem_we),
		.wr_addr    (addr_q),
		.wr_data    (mem_wdata),
		.rd_addr    (addr_q),
		.rd_data    (rd_data),
		.clear_busy (clear_busy)
	);

	// one link check per level, shared over the walk
	fltpw_link_unit #(
		.FW  (FW),
		.NFW (NFW)
	) u_link (
		.entry      (rd_data),
		.base_frame (base_q),
		.next_free  (next_free_q),
		.chk        (chk),
		.frame      (link_frame),
		.new_link   (new_link)
	);

	assign s_tready    = (state_q == ST_IDLE) && !clear_busy;
	assign s_xfer      = s_tvalid && s_tready;
	assign fin_load    = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);
	assign last_lvl    = (level_q == LVL_LEAF);
	assign frames_left = (next_free_q < FRAMES_LIM);
	assign next_idx    = level_index(va_q, level_q + 2'd1);
	assign fresh_frame = next_free_q[FW-1:0];

	// store writes in map commands: new link when a level is missing and a frame is free, or the leaf
	assign mem_we = (state_q == ST_EVAL) && (cmd_q == CMD_MAP)
		&& (last_lvl || (!chk.present && frames_left));
	assign mem_wdata = last_lvl ? {pa_page_q, flags_q} : new_link;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= LVL_ROOT;
			next_free_q <= NFW'(1);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						level_q <= LVL_ROOT;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (last_lvl) begin
						state_q <= ST_FIN;
					end else if (cmd_q == CMD_MAP && !chk.present) begin
						if (frames_left) begin
							next_free_q <= next_free_q + 1'b1;
							level_q     <= level_q + 2'd1;
							state_q     <= ST_READ;
						end else begin
							state_q <= ST_FIN;
						end
					end else if (chk.present && chk.in_store) begin
						level_q <= level_q + 2'd1;
						state_q <= ST_READ;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// command payload, walk address and pending result
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			cmd_q     <= s_tuser[0];
			va_q      <= s_tdata[47:0];
			pa_page_q <= s_tdata[99:60];
			flags_q   <= s_tdata[111:100];
			addr_q    <= {{FW{1'b0}}, level_index(s_tdata[47:0], LVL_ROOT)};
		end
		if (state_q == ST_EVAL) begin
			if (last_lvl) begin
				if (cmd_q == CMD_TRANSLATE && chk.present) begin
					res_addr_q   <= {rd_data[ENTRY_W-1:12], va_q[11:0]};
					res_status_q <= STATUS_OK;
				end else if (cmd_q == CMD_TRANSLATE) begin
					res_addr_q   <= '0;
					res_status_q <= STATUS_UNMAPPED;
				end else begin
					res_addr_q   <= '0;
					res_status_q <= STATUS_OK;
				end
			end else if (cmd_q == CMD_MAP && !chk.present) begin
				res_addr_q <= '0;
				if (frames_left) begin
					addr_q       <= {fresh_frame, next_idx};
					res_status_q <= STATUS_OK;
				end else begin
					res_status_q <= STATUS_NO_FRAMES;
				end
			end else if (chk.present && chk.in_store) begin
				addr_q       <= {link_frame, next_idx};
				res_addr_q   <= '0;
				res_status_q <= STATUS_OK;
			end else begin
				res_addr_q   <= '0;
				res_status_q <= STATUS_UNMAPPED;
			end
		end
		if (fin_load) begin
			m_addr_q   <= res_addr_q;
			m_status_q <= res_status_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - PA_W){1'b0}}, m_addr_q};
	assign m_tuser  = m_status_q;

`ifndef SYNTHESIS
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !clear_busy)
		else $error("command accepted during store sweep");

	a_free_count_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q <= FRAMES_LIM) && (next_free_q != '0))
		else $error("frame allocation count out of range");

	a_write_only_for_map: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_EVAL && cmd_q == CMD_MAP))
		else $error("store write outside map evaluation");

	a_link_write_allocates: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !last_lvl) |=> (next_free_q == $past(next_free_q) + 1'b1))
		else $error("link written without frame allocation");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && m_tvalid_q && !m_tready) |=> (state_q == ST_FIN))
		else $error("pending result dropped while output stalled");
`endif

endmodule
